// ===== hw/rtl/ndp_neighbor_solicit_framer_macros.svh =====
// assertion macros for the neighbor solicitation framer
// no dependencies; empty bodies when SYNTH is defined
`ifndef NDP_NEIGHBOR_SOLICIT_FRAMER_MACROS_SVH
`define NDP_NEIGHBOR_SOLICIT_FRAMER_MACROS_SVH

`ifndef SYNTH
// property checked on the rising clock edge, off while reset is low
`define NDPNS_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// property checked on every rising clock edge
`define NDPNS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define NDPNS_ASSERT(name, clk, rstn, prop, msg)
`define NDPNS_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/ndpns_pkg.sv =====
// shared types and constants for the neighbor solicitation framer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ndpns_pkg;

  // input beat: target ipv6 address
  typedef struct packed {
    logic [63:0] target_high;
    logic [63:0] target_low;
  } ndpns_req_t;

  // output beat: one frame word
  typedef struct packed {
    logic [63:0] frame_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } ndpns_rsp_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SRC_IP_HIGH = 2'd0,
    CFG_SRC_IP_LOW  = 2'd1,
    CFG_OWN_MAC     = 2'd2,
    CFG_UNUSED      = 2'd3
  } ndpns_cfg_e;

  localparam int unsigned WordsOut  = 11;
  localparam int unsigned CntW      = 4;
  localparam logic [CntW-1:0] LastWord = CntW'(WordsOut - 1);

  localparam logic [15:0] EtherTypeIpv6 = 16'h86DD;
  localparam logic [7:0]  IpVersionTc   = 8'h60;
  localparam logic [7:0]  NextHdrIcmp6  = 8'd58;
  localparam logic [7:0]  HopLimit      = 8'd255;
  localparam logic [7:0]  IcmpLen       = 8'd32;
  localparam logic [7:0]  IcmpTypeNs    = 8'd135;
  localparam logic [7:0]  McastMacByte  = 8'h33;
  localparam logic [7:0]  SolicitByte   = 8'hff;
  localparam logic [7:0]  LinkLocalLo   = 8'h02;
  localparam logic [7:0]  OptSrcLladdr  = 8'h01;
  localparam logic [7:0]  OptLenUnits   = 8'h01;
  localparam logic [3:0]  BytesFull     = 4'd8;
  localparam logic [3:0]  BytesTail     = 4'd6;

  localparam int unsigned SumW = 21;

  // constant halfwords of pseudo-header and message: ff02, 0001, ff00,
  // length, next header, type/code, option type/length
  localparam logic [SumW-1:0] ConstSum =
      SumW'({SolicitByte, LinkLocalLo}) + SumW'(16'h0001) + SumW'({SolicitByte, 8'h00}) +
      SumW'(IcmpLen) + SumW'(NextHdrIcmp6) + SumW'({IcmpTypeNs, 8'h00}) +
      SumW'({OptSrcLladdr, OptLenUnits});

  // sum of the four big-endian halfwords of a 64-bit word
  function automatic logic [17:0] hsum4(input logic [63:0] v);
    hsum4 = 18'(v[63:48]) + 18'(v[47:32]) + 18'(v[31:16]) + 18'(v[15:0]);
  endfunction

  // sum of the three halfwords of a mac address
  function automatic logic [17:0] hsum3(input logic [47:0] v);
    hsum3 = 18'(v[47:32]) + 18'(v[31:16]) + 18'(v[15:0]);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ndp_neighbor_solicit_framer.sv =====
// neighbor solicitation framer top level: checksum pipeline and word serializer
// depends on ndpns_pkg and ndp_neighbor_solicit_framer_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "ndp_neighbor_solicit_framer_macros.svh"

// Each accepted target address yields one 86-byte Ethernet/IPv6/ICMPv6
// neighbor solicitation frame, sent as eleven 64-bit beats, earliest byte in
// the top bits; the last beat carries six valid bytes with the low two zero.
// Beats leave one per cycle while out_stall_i is low; the output word serializer
// takes a new address only when empty or as the final beat of its frame leaves.
// An input beat passes three checksum stages (halfword sums, total, fold) and
// then the serializer register before its first output beat appears.
// Addresses enter in consecutive cycles until the three stages are full; the
// input stall then follows the serializer. Configuration writes are always
// ready and must happen only while no frame is in flight.
module ndp_neighbor_solicit_framer
  import ndpns_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  // input address channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire ndpns_req_t in_data_i,
  // output frame channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output ndpns_rsp_t  out_data_o,
  // configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [63:0] cfg_data_i
);

  // ---------------------------------------------------------------- config
  logic [63:0] src_ip_high_q, src_ip_low_q;
  logic [47:0] own_mac_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_ip_high_q <= '0;
      src_ip_low_q  <= '0;
      own_mac_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ndpns_cfg_e'(cfg_index_i))
        CFG_SRC_IP_HIGH: src_ip_high_q <= cfg_data_i;
        CFG_SRC_IP_LOW:  src_ip_low_q  <= cfg_data_i;
        CFG_OWN_MAC:     own_mac_q     <= cfg_data_i[47:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ------------------------------------------------------- stage handshake
  // each stage moves when it is empty or the next one takes its beat
  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_en, s2_en, s3_en;
  logic frm_v_q;
  logic [CntW-1:0] cnt_q;
  logic out_fire, out_last, frm_load;

  assign out_valid_o = frm_v_q;
  assign out_fire    = frm_v_q && !out_stall_i;
  assign out_last    = (cnt_q == LastWord);
  // serializer is free when empty or its final beat leaves this cycle
  assign frm_load    = s3_v_q && (!frm_v_q || (out_fire && out_last));

  assign s3_en      = !s3_v_q || frm_load;
  assign s2_en      = !s2_v_q || s3_en;
  assign s1_en      = !s1_v_q || s2_en;
  assign in_stall_o = !s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= in_valid_i;
      if (s2_en) s2_v_q <= s1_v_q;
      if (s3_en) s3_v_q <= s2_v_q;
    end
  end

  // --------------------------------------------- stage 1: halfword sums
  ndpns_req_t  s1_tgt_q;
  logic [17:0] s1_th_sum_q, s1_tl_sum_q, s1_iph_sum_q, s1_ipl_sum_q, s1_mac_sum_q;

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_tgt_q     <= in_data_i;
      s1_th_sum_q  <= hsum4(in_data_i.target_high);
      s1_tl_sum_q  <= hsum4(in_data_i.target_low);
      s1_iph_sum_q <= hsum4(src_ip_high_q);
      s1_ipl_sum_q <= hsum4(src_ip_low_q);
      s1_mac_sum_q <= hsum3(own_mac_q);
    end
  end

  // ------------------------------------------------- stage 2: full sum
  // solicited-node destination contributes ff00|t13 and t14t15; ff00 is
  // folded into the constant
  ndpns_req_t      s2_tgt_q;
  logic [SumW-1:0] s2_sum_q;
  logic [SumW-1:0] s2_sum_d;

  always_comb begin
    s2_sum_d = SumW'(s1_th_sum_q) + SumW'(s1_tl_sum_q) + SumW'(s1_iph_sum_q) +
               SumW'(s1_ipl_sum_q) + SumW'(s1_mac_sum_q) + ConstSum +
               SumW'(s1_tgt_q.target_low[23:16]) + SumW'(s1_tgt_q.target_low[15:0]);
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_tgt_q <= s1_tgt_q;
      s2_sum_q <= s2_sum_d;
    end
  end

  // ------------------------------------------ stage 3: fold and invert
  ndpns_req_t  s3_tgt_q;
  logic [15:0] s3_ck_q;
  logic [16:0] fold1;
  logic [15:0] fold2;

  always_comb begin
    fold1 = 17'(s2_sum_q[15:0]) + 17'(s2_sum_q[SumW-1:16]);
    // second carry cannot overflow: a carry out of fold1 leaves a small low half
    fold2 = fold1[15:0] + 16'(fold1[16]);
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_tgt_q <= s2_tgt_q;
      s3_ck_q  <= ~fold2;
    end
  end

  // ------------------------------------------------ output serializer
  ndpns_req_t  frm_tgt_q;
  logic [15:0] frm_ck_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_v_q <= 1'b0;
      cnt_q   <= '0;
    end else if (frm_load) begin
      frm_v_q <= 1'b1;
      cnt_q   <= '0;
    end else if (out_fire) begin
      if (out_last) begin
        frm_v_q <= 1'b0;
        cnt_q   <= '0;
      end else begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frm_load) begin
      frm_tgt_q <= s3_tgt_q;
      frm_ck_q  <= s3_ck_q;
    end
  end

  // frame layout, eight bytes per beat
  logic [63:0] th, tl;
  assign th = frm_tgt_q.target_high;
  assign tl = frm_tgt_q.target_low;

  always_comb begin
    out_data_o.valid_bytes = out_last ? BytesTail : BytesFull;
    out_data_o.last_word   = out_last;
    case (cnt_q)
      4'd0:    out_data_o.frame_word = {McastMacByte, McastMacByte, SolicitByte,
                                        tl[23:0], own_mac_q[47:32]};
      4'd1:    out_data_o.frame_word = {own_mac_q[31:0], EtherTypeIpv6,
                                        IpVersionTc, 8'h00};
      4'd2:    out_data_o.frame_word = {24'h0, IcmpLen, NextHdrIcmp6, HopLimit,
                                        src_ip_high_q[63:48]};
      4'd3:    out_data_o.frame_word = {src_ip_high_q[47:0], src_ip_low_q[63:48]};
      4'd4:    out_data_o.frame_word = {src_ip_low_q[47:0], SolicitByte, LinkLocalLo};
      4'd5:    out_data_o.frame_word = 64'h0;
      4'd6:    out_data_o.frame_word = {8'h00, 8'h01, SolicitByte, tl[23:0],
                                        IcmpTypeNs, 8'h00};
      4'd7:    out_data_o.frame_word = {frm_ck_q, 32'h0, th[63:48]};
      4'd8:    out_data_o.frame_word = {th[47:0], tl[63:48]};
      4'd9:    out_data_o.frame_word = {tl[47:0], OptSrcLladdr, OptLenUnits};
      4'd10:   out_data_o.frame_word = {own_mac_q, 16'h0};
      default: out_data_o.frame_word = 64'h0;
    endcase
  end

  // ------------------------------------------------------------ checks
  `NDPNS_ASSERT(a_frame_continues, clk_i, rst_ni,
    out_fire && !out_last |=> out_valid_o && (cnt_q == $past(cnt_q) + CntW'(1)),
    "frame beat lost between words")
  `NDPNS_ASSERT(a_stall_holds_count, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cnt_q),
    "word counter moved while output stalled")
  `NDPNS_ASSERT(a_load_when_free, clk_i, rst_ni,
    frm_load |-> !frm_v_q || (out_fire && out_last),
    "serializer overwritten mid frame")
  `NDPNS_ASSERT(a_count_in_range, clk_i, rst_ni,
    frm_v_q |-> cnt_q <= LastWord,
    "word counter past final word")

endmodule

`default_nettype wire
